// File: rtl/assert_macros.svh
// Assertion macros for the stride scheduler RTL.
// Depends on signals named clk and rst in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stride scheduler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stride scheduler assertion failed");

`endif

// File: rtl/ss_pkg.sv
`timescale 1ns / 1ps
// Types, codes and micro-programs for the stride scheduler.
// No dependencies; used by every other file of the block but ss_arith and the assertion macros.
package ss_pkg;

  localparam int OPW = 3;
  localparam int CLW = 4;
  localparam int TKW = 21;
  localparam int TW  = 48;
  localparam int STW = 3;
  localparam int QCW = 5;
  localparam int TTW = 25;

  localparam logic [OPW-1:0] OP_INIT   = 3'd0;
  localparam logic [OPW-1:0] OP_JOIN   = 3'd1;
  localparam logic [OPW-1:0] OP_YIELD  = 3'd2;
  localparam logic [OPW-1:0] OP_BLOCK  = 3'd3;
  localparam logic [OPW-1:0] OP_LEAVE  = 3'd4;
  localparam logic [OPW-1:0] OP_MODIFY = 3'd5;
  localparam logic [OPW-1:0] OP_PICK   = 3'd6;

  localparam logic [STW-1:0] ST_OK         = 3'd0;
  localparam logic [STW-1:0] ST_BAD_TICKET = 3'd1;
  localparam logic [STW-1:0] ST_QUEUED     = 3'd2;
  localparam logic [STW-1:0] ST_NOT_QUEUED = 3'd3;
  localparam logic [STW-1:0] ST_EMPTY      = 3'd4;

  localparam logic [1:0]     ADDR_TICK_LENGTH = 2'd0;
  localparam logic [31:0]    TICK_RESET       = 32'd10;
  localparam logic [63:0]    TIME_SCALE       = 64'd1000000;
  localparam logic [TTW-1:0] TOTAL_MAX        = 25'h1FFFFFF;

  typedef enum logic [5:0] {
    U_NOP, U_END, U_LATCH, U_READ, U_LOAD, U_WRITE,
    U_SCAN_INIT, U_SCAN_RD, U_SCAN_CMP, U_PICK_TAKE, U_SET_START, U_OUT,
    U_GCHG_EL, U_CCHG_EL, U_GCHG_STR, U_CCHG_STR, U_CHG_DEN,
    U_GCHG_DIV, U_CCHG_DIV, U_RESTRIDE, U_NEWSTRIDE, U_REM_MUL, U_REM_DIV,
    U_TICKETS_SET, U_INIT_STR, U_INIT_PASS, U_TADD, U_TSUB,
    U_ENQ, U_DEQ, U_JOIN_PASS, U_LEAVE_REM, U_MOD_SET
  } uop_t;

  typedef enum logic [1:0] {C_ALWAYS, C_NOINIT, C_Q, C_QCUR} cond_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOAD, S_DISPATCH, S_RUN, S_WAIT,
    S_SCAN_RD, S_SCAN_CMP, S_PICK_CHK, S_PICK_RD, S_PICK_LD,
    S_PICK_SET, S_PICK_WR, S_DONE
  } ctl_state_t;

  typedef struct packed {
    uop_t           uop;
    logic [STW-1:0] status;
  } dp_ctl_t;

  typedef struct packed {
    logic [OPW-1:0] opcode;
    logic           client_ok;
    logic           queued;
    logic           cur;
    logic           init_done;
    logic           tk_ok;
    logic           arith_done;
    logic           scan_last;
    logic           found;
  } dp_stat_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
  } prog_t;

  localparam prog_t PEND = '{U_END, C_ALWAYS};

  localparam prog_t PROG_INIT [32] = '{
    0: '{U_TICKETS_SET, C_ALWAYS}, 1: '{U_NEWSTRIDE, C_ALWAYS},
    2: '{U_INIT_STR, C_ALWAYS},    3: '{U_TADD, C_NOINIT},
    4: '{U_RESTRIDE, C_NOINIT},    5: '{U_GCHG_EL, C_NOINIT},
    6: '{U_GCHG_STR, C_NOINIT},    7: '{U_CHG_DEN, C_NOINIT},
    8: '{U_GCHG_DIV, C_NOINIT},    9: '{U_INIT_PASS, C_NOINIT},
    default: PEND};

  localparam prog_t PROG_JOIN [32] = '{
    0: '{U_GCHG_EL, C_ALWAYS},   1: '{U_GCHG_STR, C_ALWAYS},
    2: '{U_CHG_DEN, C_ALWAYS},   3: '{U_GCHG_DIV, C_ALWAYS},
    4: '{U_JOIN_PASS, C_ALWAYS}, 5: '{U_TADD, C_ALWAYS},
    6: '{U_RESTRIDE, C_ALWAYS},  7: '{U_ENQ, C_ALWAYS},
    default: PEND};

  localparam prog_t PROG_YIELD [32] = '{
    0: '{U_CCHG_EL, C_ALWAYS}, 1: '{U_CCHG_STR, C_ALWAYS},
    2: '{U_CHG_DEN, C_ALWAYS}, 3: '{U_CCHG_DIV, C_ALWAYS},
    4: '{U_ENQ, C_ALWAYS},
    default: PEND};

  localparam prog_t PROG_BLOCK [32] = '{
    0: '{U_CCHG_EL, C_ALWAYS},    1: '{U_CCHG_STR, C_ALWAYS},
    2: '{U_CHG_DEN, C_ALWAYS},    3: '{U_CCHG_DIV, C_ALWAYS},
    4: '{U_GCHG_EL, C_ALWAYS},    5: '{U_GCHG_STR, C_ALWAYS},
    6: '{U_CHG_DEN, C_ALWAYS},    7: '{U_GCHG_DIV, C_ALWAYS},
    8: '{U_LEAVE_REM, C_ALWAYS},  9: '{U_TSUB, C_ALWAYS},
    10: '{U_RESTRIDE, C_ALWAYS},
    default: PEND};

  localparam prog_t PROG_LEAVE [32] = '{
    0: '{U_DEQ, C_ALWAYS},       1: '{U_GCHG_EL, C_ALWAYS},
    2: '{U_GCHG_STR, C_ALWAYS},  3: '{U_CHG_DEN, C_ALWAYS},
    4: '{U_GCHG_DIV, C_ALWAYS},  5: '{U_LEAVE_REM, C_ALWAYS},
    6: '{U_TSUB, C_ALWAYS},      7: '{U_RESTRIDE, C_ALWAYS},
    default: PEND};

  localparam prog_t PROG_MODIFY [32] = '{
    0: '{U_DEQ, C_Q},            1: '{U_GCHG_EL, C_Q},
    2: '{U_GCHG_STR, C_Q},       3: '{U_CHG_DEN, C_Q},
    4: '{U_GCHG_DIV, C_Q},       5: '{U_LEAVE_REM, C_Q},
    6: '{U_TSUB, C_QCUR},        7: '{U_RESTRIDE, C_QCUR},
    8: '{U_NEWSTRIDE, C_ALWAYS}, 9: '{U_REM_MUL, C_ALWAYS},
    10: '{U_REM_DIV, C_ALWAYS},  11: '{U_MOD_SET, C_ALWAYS},
    12: '{U_GCHG_EL, C_Q},       13: '{U_GCHG_STR, C_Q},
    14: '{U_CHG_DEN, C_Q},       15: '{U_GCHG_DIV, C_Q},
    16: '{U_JOIN_PASS, C_Q},     17: '{U_TADD, C_QCUR},
    18: '{U_RESTRIDE, C_QCUR},   19: '{U_ENQ, C_Q},
    default: PEND};

  function automatic prog_t prog_entry(input logic [OPW-1:0] op, input logic [4:0] pc);
    prog_t e;
    e = PEND;
    case (op)
      OP_INIT:   e = PROG_INIT[pc];
      OP_JOIN:   e = PROG_JOIN[pc];
      OP_YIELD:  e = PROG_YIELD[pc];
      OP_BLOCK:  e = PROG_BLOCK[pc];
      OP_LEAVE:  e = PROG_LEAVE[pc];
      OP_MODIFY: e = PROG_MODIFY[pc];
      default:   e = PEND;
    endcase
    return e;
  endfunction

  function automatic logic is_arith(input uop_t u);
    logic r;
    case (u) inside
      U_GCHG_EL, U_CCHG_EL, U_GCHG_STR, U_CCHG_STR, U_CHG_DEN,
      U_GCHG_DIV, U_CCHG_DIV, U_RESTRIDE, U_NEWSTRIDE, U_REM_MUL,
      U_REM_DIV: r = 1'b1;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scheduler requests and results.
// Depends on ss_pkg for the field widths.
interface ss_in_if;
  import ss_pkg::*;
  logic           valid;
  logic           ready;
  logic [OPW-1:0] opcode;
  logic [CLW-1:0] client;
  logic [TKW-1:0] tickets;
  logic [TW-1:0]  now;
  logic           is_current;
  modport source (output valid, opcode, client, tickets, now, is_current, input ready);
  modport sink   (input valid, opcode, client, tickets, now, is_current, output ready);
endinterface

interface ss_out_if;
  import ss_pkg::*;
  logic           valid;
  logic           ready;
  logic [STW-1:0] status;
  logic           next_valid;
  logic [CLW-1:0] next_client;
  logic [QCW-1:0] queued_count;
  modport source (output valid, status, next_valid, next_client, queued_count, input ready);
  modport sink   (input valid, status, next_valid, next_client, queued_count, output ready);
endinterface

// File: rtl/ss_arith.sv
`timescale 1ns / 1ps
// Shared serial unit: 64-bit wrapping shift-add multiply and restoring divide of a
// signed dividend by an unsigned divisor, one bit a cycle. Depends on nothing.
module ss_arith (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_div,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);
  logic        busy;
  logic        mode;
  logic        neg;
  logic [5:0]  cnt;
  logic [63:0] x;
  logic [63:0] y;
  logic [64:0] p;
  logic [64:0] rsh;
  logic        qbit;
  logic [63:0] qn;

  assign rsh  = {p[63:0], x[63]};
  assign qbit = rsh >= {1'b0, y};
  assign qn   = {x[62:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        mode <= is_div;
        neg  <= is_div & a[63];
        x    <= (is_div && a[63]) ? (64'd0 - a) : a;
        y    <= b;
        p    <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (!mode) begin
          if (y == 64'd0) begin
            res  <= p[63:0];
            done <= 1'b1;
            busy <= 1'b0;
          end else begin
            if (y[0]) p <= 65'(p[63:0] + x);
            x <= {x[62:0], 1'b0};
            y <= {1'b0, y[63:1]};
          end
        end else begin
          p   <= qbit ? (rsh - {1'b0, y}) : rsh;
          x   <= qn;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            res  <= neg ? (64'd0 - qn) : qn;
            done <= 1'b1;
            busy <= 1'b0;
          end
        end
      end
    end
  end
endmodule

// File: rtl/ss_datapath.sv
`timescale 1ns / 1ps
// Scheduler datapath: client table memory, global totals, pick scan,
// operand selection for the serial unit and the result register.
// Depends on ss_pkg and ss_arith.
module ss_datapath #(
  parameter int NUM_CLIENTS     = 16,
  parameter int STRIDE_ONE_LOG2 = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ss_pkg::dp_ctl_t        ctl,
  output ss_pkg::dp_stat_t       stat,
  input  logic [ss_pkg::OPW-1:0] opcode,
  input  logic [ss_pkg::CLW-1:0] client,
  input  logic [ss_pkg::TKW-1:0] tickets,
  input  logic [ss_pkg::TW-1:0]  now,
  input  logic                   is_current,
  input  logic [31:0]            tick_length,
  output logic [ss_pkg::STW-1:0] status,
  output logic                   next_valid,
  output logic [ss_pkg::CLW-1:0] next_client,
  output logic [ss_pkg::QCW-1:0] queued_count
);
  import ss_pkg::*;

  localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int QW = $clog2(NUM_CLIENTS + 1);
  localparam int SW = STRIDE_ONE_LOG2 + 1;
  localparam logic [63:0] STRIDE_ONE = 64'd1 << STRIDE_ONE_LOG2;

  typedef struct packed {
    logic [TKW-1:0] tickets;
    logic [SW-1:0]  stride;
    logic [63:0]    pass;
    logic [63:0]    remain;
    logic [TW-1:0]  start;
    logic [31:0]    order;
  } rec_t;

  rec_t mem [NUM_CLIENTS];
  rec_t rdata;
  rec_t rec;
  logic [CW-1:0] raddr;

  logic [OPW-1:0] op_r;
  logic [CW-1:0]  cidx;
  logic           client_ok;
  logic [TKW-1:0] tk_r;
  logic [TW-1:0]  now_r;
  logic           cur_r;
  logic           q_lat;

  logic [NUM_CLIENTS-1:0] queued;
  logic [QW-1:0]  qcount;
  logic [31:0]    insert_counter;
  logic [TTW-1:0] total_tickets;
  logic [SW-1:0]  total_stride;
  logic [63:0]    total_pass;
  logic [TW-1:0]  last_update;
  logic           init_done;

  logic [63:0]    acc;
  logic [63:0]    den;
  logic [SW-1:0]  ns;
  uop_t           pend;

  logic [CW-1:0]  scan_idx;
  logic [CW-1:0]  best_idx;
  logic [63:0]    best_pass;
  logic [31:0]    best_age;
  logic           found;
  logic           picked;

  logic [STW-1:0] res_status;
  logic           res_nvalid;
  logic [CW-1:0]  res_nclient;
  logic [QW-1:0]  res_count;

  logic           ar_start;
  logic           ar_div;
  logic [63:0]    ar_a;
  logic [63:0]    ar_b;
  logic           ar_done;
  logic [63:0]    ar_res;

  logic [31:0]    teff;
  logic [TTW:0]   tt_sum;
  logic [31:0]    age;
  logic           take;

  assign teff   = (tick_length == 32'd0) ? 32'd1 : tick_length;
  assign tt_sum = {1'b0, total_tickets} + (TTW+1)'(rec.tickets);
  assign age    = insert_counter - rdata.order;
  assign take   = queued[scan_idx] &&
                  (!found || ($signed(rdata.pass) < $signed(best_pass)) ||
                   ((rdata.pass == best_pass) && (age > best_age)));
  assign raddr  = (ctl.uop == U_SCAN_RD) ? scan_idx : cidx;

  always_comb begin
    stat.opcode     = op_r;
    stat.client_ok  = client_ok;
    stat.queued     = q_lat;
    stat.cur        = cur_r;
    stat.init_done  = init_done;
    stat.tk_ok      = (tk_r != '0) && (32'(tk_r) <= (32'd1 << STRIDE_ONE_LOG2));
    stat.arith_done = ar_done;
    stat.scan_last  = scan_idx == CW'(NUM_CLIENTS - 1);
    stat.found      = found;
  end

  // Operand selection for the serial unit
  always_comb begin
    ar_a   = '0;
    ar_b   = '0;
    ar_div = 1'b0;
    case (ctl.uop)
      U_GCHG_EL:   begin ar_a = 64'(now_r) - 64'(last_update); ar_b = TIME_SCALE; end
      U_CCHG_EL:   begin ar_a = 64'(now_r) - 64'(rec.start);   ar_b = TIME_SCALE; end
      U_GCHG_STR:  begin ar_a = 64'(total_stride); ar_b = acc; end
      U_CCHG_STR:  begin ar_a = 64'(rec.stride);   ar_b = acc; end
      U_CHG_DEN:   begin ar_a = 64'(teff);         ar_b = TIME_SCALE; end
      U_GCHG_DIV,
      U_CCHG_DIV:  begin ar_a = acc; ar_b = den; ar_div = 1'b1; end
      U_RESTRIDE:  begin ar_a = STRIDE_ONE; ar_b = 64'(total_tickets); ar_div = 1'b1; end
      U_NEWSTRIDE: begin ar_a = STRIDE_ONE; ar_b = 64'(tk_r); ar_div = 1'b1; end
      U_REM_MUL:   begin ar_a = rec.remain; ar_b = 64'(ns); end
      U_REM_DIV:   begin ar_a = acc; ar_b = 64'(rec.stride); ar_div = 1'b1; end
      default:     ;
    endcase
  end
  assign ar_start = is_arith(ctl.uop);

  ss_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .start  (ar_start),
    .is_div (ar_div),
    .a      (ar_a),
    .b      (ar_b),
    .done   (ar_done),
    .res    (ar_res)
  );

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (ctl.uop == U_WRITE) mem[cidx] <= rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queued         <= '0;
      qcount         <= '0;
      insert_counter <= '0;
      total_tickets  <= '0;
      total_stride   <= '0;
      total_pass     <= '0;
      last_update    <= '0;
      init_done      <= 1'b0;
      found          <= 1'b0;
      picked         <= 1'b0;
    end else begin
      if (ar_start) pend <= ctl.uop;
      case (ctl.uop)
        U_LATCH: begin
          op_r      <= opcode;
          cidx      <= CW'(client);
          client_ok <= 32'(client) < NUM_CLIENTS;
          tk_r      <= tickets;
          now_r     <= now;
          cur_r     <= is_current;
          picked    <= 1'b0;
        end
        U_LOAD: begin
          rec   <= rdata;
          q_lat <= queued[cidx];
        end
        U_SCAN_INIT: begin
          scan_idx <= '0;
          found    <= 1'b0;
        end
        U_SCAN_CMP: begin
          if (take) begin
            best_idx  <= scan_idx;
            best_pass <= rdata.pass;
            best_age  <= age;
            found     <= 1'b1;
          end
          scan_idx <= scan_idx + CW'(1);
        end
        U_PICK_TAKE: begin
          cidx             <= best_idx;
          queued[best_idx] <= 1'b0;
          qcount           <= qcount - QW'(1);
          picked           <= 1'b1;
        end
        U_SET_START:   rec.start <= now_r;
        U_TICKETS_SET: rec.tickets <= tk_r;
        U_INIT_STR: begin
          rec.stride <= ns;
          rec.remain <= 64'(ns);
        end
        U_INIT_PASS: begin
          rec.pass  <= total_pass;
          init_done <= 1'b1;
        end
        U_TADD: total_tickets <= tt_sum[TTW] ? TOTAL_MAX : tt_sum[TTW-1:0];
        U_TSUB: total_tickets <= (TTW'(rec.tickets) > total_tickets) ? '0
                                 : total_tickets - TTW'(rec.tickets);
        U_ENQ: begin
          queued[cidx]   <= 1'b1;
          rec.order      <= insert_counter;
          insert_counter <= insert_counter + 32'd1;
          qcount         <= qcount + QW'(1);
        end
        U_DEQ: begin
          queued[cidx] <= 1'b0;
          qcount       <= qcount - QW'(1);
        end
        U_JOIN_PASS: rec.pass   <= total_pass + rec.remain;
        U_LEAVE_REM: rec.remain <= rec.pass - total_pass;
        U_MOD_SET: begin
          rec.tickets <= tk_r;
          rec.stride  <= ns;
        end
        U_OUT: begin
          res_status  <= ctl.status;
          res_nvalid  <= picked;
          res_nclient <= picked ? best_idx : '0;
          res_count   <= qcount;
        end
        default: ;
      endcase
      // Retire the pending serial operation
      if (ar_done) begin
        case (pend)
          U_GCHG_EL, U_CCHG_EL, U_GCHG_STR, U_CCHG_STR, U_REM_MUL: acc <= ar_res;
          U_CHG_DEN: den <= ar_res;
          U_GCHG_DIV: begin
            total_pass  <= total_pass + ar_res;
            last_update <= now_r;
          end
          U_CCHG_DIV:  rec.pass <= rec.pass + ar_res;
          U_RESTRIDE:  total_stride <= (total_tickets == '0) ? STRIDE_ONE[SW-1:0]
                                       : ar_res[SW-1:0];
          U_NEWSTRIDE: ns <= ar_res[SW-1:0];
          U_REM_DIV:   rec.remain <= (rec.stride == '0) ? 64'd0 : ar_res;
          default: ;
        endcase
      end
    end
  end

  assign status       = res_status;
  assign next_valid   = res_nvalid;
  assign next_client  = CLW'(res_nclient);
  assign queued_count = QCW'(res_count);
endmodule

// File: rtl/ss_ctrl.sv
`timescale 1ns / 1ps
// Scheduler controller: request decode, micro-program sequencing,
// pick scan control and the output valid flag. Depends on ss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ss_pkg::dp_ctl_t   ctl,
  input  ss_pkg::dp_stat_t  stat
);
  import ss_pkg::*;

  ctl_state_t     state, state_next;
  logic [4:0]     pc, pc_next;
  logic [STW-1:0] code, code_next;
  logic           out_vld;
  prog_t          ent;
  logic           cond_ok;
  logic           slot_free;

  assign slot_free = !out_vld || out_ready;
  assign ent       = prog_entry(stat.opcode, pc);

  always_comb begin
    case (ent.cond)
      C_ALWAYS: cond_ok = 1'b1;
      C_NOINIT: cond_ok = !stat.init_done;
      C_Q:      cond_ok = stat.queued;
      C_QCUR:   cond_ok = stat.queued || stat.cur;
      default:  cond_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pc      <= '0;
      code    <= ST_OK;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      code  <= code_next;
      if (state == S_DONE && slot_free) out_vld <= 1'b1;
      else if (out_ready)               out_vld <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    code_next  = code;
    ctl.uop    = U_NOP;
    ctl.status = code;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.uop    = U_LATCH;
          code_next  = ST_OK;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.opcode == OP_PICK) begin
          ctl.uop    = U_SCAN_INIT;
          state_next = S_SCAN_RD;
        end else if (stat.opcode < OP_PICK && stat.client_ok) begin
          ctl.uop    = U_READ;
          state_next = S_LOAD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LOAD: begin
        ctl.uop    = U_LOAD;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        pc_next    = '0;
        state_next = S_RUN;
        unique case (stat.opcode)
          OP_INIT: begin
            if (!stat.tk_ok)     begin code_next = ST_BAD_TICKET; state_next = S_DONE; end
            else if (stat.queued) begin code_next = ST_QUEUED;     state_next = S_DONE; end
          end
          OP_JOIN, OP_YIELD, OP_BLOCK: begin
            if (stat.queued) begin code_next = ST_QUEUED; state_next = S_DONE; end
          end
          OP_LEAVE: begin
            if (!stat.queued) begin code_next = ST_NOT_QUEUED; state_next = S_DONE; end
          end
          OP_MODIFY: begin
            if (!stat.tk_ok) begin code_next = ST_BAD_TICKET; state_next = S_DONE; end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RUN: begin
        if (ent.uop == U_END) begin
          ctl.uop    = U_WRITE;
          state_next = S_DONE;
        end else if (!cond_ok) begin
          pc_next = pc + 5'd1;
        end else begin
          ctl.uop = ent.uop;
          if (is_arith(ent.uop)) state_next = S_WAIT;
          else                   pc_next = pc + 5'd1;
        end
      end
      S_WAIT: begin
        if (stat.arith_done) begin
          pc_next    = pc + 5'd1;
          state_next = S_RUN;
        end
      end
      S_SCAN_RD: begin
        ctl.uop    = U_SCAN_RD;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        ctl.uop    = U_SCAN_CMP;
        state_next = stat.scan_last ? S_PICK_CHK : S_SCAN_RD;
      end
      S_PICK_CHK: begin
        if (stat.found) begin
          ctl.uop    = U_PICK_TAKE;
          state_next = S_PICK_RD;
        end else begin
          code_next  = ST_EMPTY;
          state_next = S_DONE;
        end
      end
      S_PICK_RD: begin
        ctl.uop    = U_READ;
        state_next = S_PICK_LD;
      end
      S_PICK_LD: begin
        ctl.uop    = U_LOAD;
        state_next = S_PICK_SET;
      end
      S_PICK_SET: begin
        ctl.uop    = U_SET_START;
        state_next = S_PICK_WR;
      end
      S_PICK_WR: begin
        ctl.uop    = U_WRITE;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold the word until the output register is free
        if (slot_free) begin
          ctl.uop    = U_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = out_vld;

  `SS_ASSERT_IMP(a_done_in_wait, stat.arith_done, state == S_WAIT)
  `SS_ASSERT_IMP(a_arith_from_run, is_arith(ctl.uop), state == S_RUN)
  `SS_ASSERT_NXT(a_out_loaded, state == S_DONE && state_next == S_IDLE, out_vld)
endmodule

// File: rtl/stride_scheduler_top.sv
// Stride scheduler: one result word per request word, one request at a time.
// A pick scans every table entry in turn, reading and then comparing each, and then
// reads, updates and writes back the chosen entry; other opcodes run a micro-program
// whose multiply and divide steps each go through the one shared bit-serial unit.
// A new request is taken while the previous result waits in the output register.
// Reset (synchronous): queue empty, totals zero, tick_length 10; table contents undefined.
`timescale 1ns / 1ps
module stride_scheduler_top #(
  parameter int NUM_CLIENTS     = 16,
  parameter int STRIDE_ONE_LOG2 = 20
) (
  input  logic        clk,
  input  logic        rst,
  ss_in_if.sink       in_ch,
  ss_out_if.source    out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ss_pkg::*;

  logic [31:0] tick_length;
  dp_ctl_t     ctl;
  dp_stat_t    stat;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TICK_LENGTH) ? tick_length : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length <= TICK_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TICK_LENGTH) begin
      tick_length <= pwdata;
    end
  end

  ss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  ss_datapath #(
    .NUM_CLIENTS     (NUM_CLIENTS),
    .STRIDE_ONE_LOG2 (STRIDE_ONE_LOG2)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .stat         (stat),
    .opcode       (in_ch.opcode),
    .client       (in_ch.client),
    .tickets      (in_ch.tickets),
    .now          (in_ch.now),
    .is_current   (in_ch.is_current),
    .tick_length  (tick_length),
    .status       (out_ch.status),
    .next_valid   (out_ch.next_valid),
    .next_client  (out_ch.next_client),
    .queued_count (out_ch.queued_count)
  );
endmodule
